// ----- src/erq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erq_pkg
// Types and constants shared by the event ring queue.
// ----------------------------------------------------------------------------
package erq_pkg;

  localparam int unsigned DEPTH_DEF       = 64;
  localparam int unsigned MAX_READERS_DEF = 255;

  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_OPEN   = 2'd2,
    KIND_CLOSE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_POP_EMPTY   = 2'd1,
    ST_DROP_FULL   = 2'd2,
    ST_DROP_NO_RDR = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] in_type;
    logic [15:0] in_code;
    logic [31:0] in_value;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic        event_valid;
    logic [15:0] out_type;
    logic [15:0] out_code;
    logic [31:0] out_value;
    logic        is_empty;
    logic [7:0]  readers_now;
  } rsp_t;

  typedef struct packed {
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
  } slot_t;

endpackage
`default_nettype wire

// ----- src/event_ring_queue.sv -----
`default_nettype none
// An accepted item's result is registered and shows on rsp in the next cycle.
// Throughput: one item per cycle while rsp is not stalled; the output register frees as rsp is taken.
// The slot memory is written and read at one address each per cycle.
// Reset clears pointers, reader count, buffer_events and the output valid;
// slot contents are left as they are.
// ----------------------------------------------------------------------------
// event_ring_queue
// Ring buffer of events with an open-reader count. Submit, pop, open and
// close commands update the ring; each command returns one status result.
// ----------------------------------------------------------------------------
module event_ring_queue #(
  parameter int unsigned DEPTH       = erq_pkg::DEPTH_DEF,
  parameter int unsigned MAX_READERS = erq_pkg::MAX_READERS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire erq_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output erq_pkg::rsp_t      rsp,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_data
);
  import erq_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(MAX_READERS + 1);
  localparam int unsigned RW = (CW > 8) ? CW : 8;

  slot_t         mem [DEPTH];
  slot_t         rd_data;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [CW-1:0] count, count_next;
  logic          buffer_events;

  status_t       status, status_next;
  logic          ev_valid, ev_valid_next;
  logic          is_empty;
  logic [RW-1:0] count_ext;

  logic          accept;
  logic          store;
  logic [PW-1:0] wr_ptr_inc, rd_ptr_inc;

  assign cfg_ready = 1'b1;
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign wr_ptr_inc = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_comb begin
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    count_next    = count;
    status_next   = ST_OK;
    ev_valid_next = 1'b0;
    store         = 1'b0;
    case (cmd.kind)
      KIND_SUBMIT: begin
        // no-reader drop wins over full
        if (count == '0 && !buffer_events) begin
          status_next = ST_DROP_NO_RDR;
        end else if (wr_ptr_inc == rd_ptr) begin
          status_next = ST_DROP_FULL;
        end else begin
          store       = 1'b1;
          wr_ptr_next = wr_ptr_inc;
        end
      end
      KIND_POP: begin
        if (wr_ptr == rd_ptr) begin
          status_next = ST_POP_EMPTY;
        end else begin
          ev_valid_next = 1'b1;
          rd_ptr_next   = rd_ptr_inc;
        end
      end
      KIND_OPEN: begin
        if (count < CW'(MAX_READERS)) count_next = count + 1'b1;
      end
      KIND_CLOSE: begin
        if (count != '0) begin
          count_next = count - 1'b1;
          // last reader gone with buffering off: flush pending events
          if (count == CW'(1) && !buffer_events) wr_ptr_next = rd_ptr;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      count         <= '0;
      buffer_events <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) buffer_events <= cfg_data;
      if (accept) begin
        rd_ptr    <= rd_ptr_next;
        wr_ptr    <= wr_ptr_next;
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      ev_valid <= ev_valid_next;
      is_empty <= (wr_ptr_next == rd_ptr_next);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      mem[wr_ptr] <= '{ev_type: cmd.in_type, ev_code: cmd.in_code, ev_value: cmd.in_value};
    end
    if (accept && cmd.kind == KIND_POP) begin
      rd_data <= mem[rd_ptr];
    end
  end

  assign count_ext = RW'(count);

  always_comb begin
    rsp.status      = status;
    rsp.event_valid = ev_valid;
    rsp.out_type    = ev_valid ? rd_data.ev_type  : 16'd0;
    rsp.out_code    = ev_valid ? rd_data.ev_code  : 16'd0;
    rsp.out_value   = ev_valid ? rd_data.ev_value : 32'd0;
    rsp.is_empty    = is_empty;
    rsp.readers_now = count_ext[7:0];
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_READERS))
    else $error("reader count above maximum");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (wr_ptr == rd_ptr)))
    else $error("empty flag disagrees with pointers");

  a_event_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.event_valid |-> rsp.status == ST_OK)
    else $error("event returned with error status");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.kind == KIND_POP && wr_ptr != rd_ptr |=> rd_ptr == $past(rd_ptr_inc))
    else $error("pop did not advance read pointer");

  a_no_store_drop: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.kind == KIND_SUBMIT && count == '0 && !buffer_events
      |=> wr_ptr == $past(wr_ptr))
    else $error("dropped event moved write pointer");

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for event_ring_queue. A tracker class keeps its own copy
// of the ring, pointers, reader count and buffering flag, predicts the result
// of each accepted item and matches the results the block returns in order.
// Directed items hit the corner cases, then random phases fill and drain the
// ring, saturate and release the reader count, and flip buffering on and off
// while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import erq_pkg::*;

  class ring_tracker;
    slot_t       ring [DEPTH_DEF];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    int unsigned reader_cnt;
    bit          buffering;
    rsp_t        due_results [$];
    int unsigned errors;

    function int unsigned next_pos(int unsigned p);
      return (p + 1) % DEPTH_DEF;
    endfunction

    function int unsigned stored();
      return (wr_ptr + DEPTH_DEF - rd_ptr) % DEPTH_DEF;
    endfunction

    function void apply_cmd(cmd_t c);
      rsp_t r;
      r = '0;
      case (c.kind)
        KIND_SUBMIT: begin
          // no-reader drop wins over full
          if (reader_cnt == 0 && !buffering) begin
            r.status = ST_DROP_NO_RDR;
          end else if (next_pos(wr_ptr) == rd_ptr) begin
            r.status = ST_DROP_FULL;
          end else begin
            ring[wr_ptr] = '{c.in_type, c.in_code, c.in_value};
            wr_ptr = next_pos(wr_ptr);
          end
        end
        KIND_POP: begin
          if (wr_ptr == rd_ptr) begin
            r.status = ST_POP_EMPTY;
          end else begin
            r.event_valid = 1'b1;
            r.out_type    = ring[rd_ptr].ev_type;
            r.out_code    = ring[rd_ptr].ev_code;
            r.out_value   = ring[rd_ptr].ev_value;
            rd_ptr = next_pos(rd_ptr);
          end
        end
        KIND_OPEN: begin
          if (reader_cnt < MAX_READERS_DEF) reader_cnt++;
        end
        KIND_CLOSE: begin
          if (reader_cnt != 0) begin
            reader_cnt--;
            // last reader gone with buffering off: pending events are dropped
            if (reader_cnt == 0 && !buffering) wr_ptr = rd_ptr;
          end
        end
        default: begin
          r.status = ST_OK;
        end
      endcase
      r.is_empty    = (wr_ptr == rd_ptr);
      r.readers_now = reader_cnt[7:0];
      due_results.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (due_results.size() == 0) begin
        $error("result with none expected: %h", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      cmp("status", 32'(want.status), 32'(got.status));
      cmp("event_valid", 32'(want.event_valid), 32'(got.event_valid));
      cmp("out_type", 32'(want.out_type), 32'(got.out_type));
      cmp("out_code", 32'(want.out_code), 32'(got.out_code));
      cmp("out_value", want.out_value, got.out_value);
      cmp("is_empty", 32'(want.is_empty), 32'(got.is_empty));
      cmp("readers_now", 32'(want.readers_now), 32'(got.readers_now));
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst;
  logic  cmd_valid;
  logic  cmd_stall;
  cmd_t  cmd;
  logic  rsp_valid;
  logic  rsp_stall;
  rsp_t  rsp;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_data;

  ring_tracker trk = new();
  int unsigned burst_left = 0;

  event_ring_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) trk.check_result(rsp);
  end

  // receiver: stall pattern switches among four modes at random, plus long hold-offs
  initial begin : rx_stall
    int unsigned cyc;
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned mode;
    cyc       = 0;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 300 || cyc == 1500) hold_left = 80;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (mode)
          0:       rsp_stall <= 1'b0;
          1:       rsp_stall <= 1'($urandom_range(0, 1));
          2:       rsp_stall <= ($urandom_range(0, 3) != 0);
          default: rsp_stall <= (cyc % 5 == 0);
        endcase
      end
    end
  end

  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t rand_cmd(kind_t k);
    cmd_t c;
    c.kind     = k;
    c.in_type  = rand16();
    c.in_code  = rand16();
    c.in_value = rand32();
    return c;
  endfunction

  function automatic kind_t pick_kind(int unsigned w_sub, int unsigned w_pop,
                                      int unsigned w_open, int unsigned w_close);
    int unsigned r;
    r = $urandom_range(0, w_sub + w_pop + w_open + w_close - 1);
    if (r < w_sub) return KIND_SUBMIT;
    if (r < w_sub + w_pop) return KIND_POP;
    if (r < w_sub + w_pop + w_open) return KIND_OPEN;
    return KIND_CLOSE;
  endfunction

  // sender works in bursts; valid only drops between bursts
  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    burst_left--;
    do @(posedge clk); while (cmd_stall);
    trk.apply_cmd(c);
  endtask

  task automatic send_kind(kind_t k);
    send_cmd(rand_cmd(k));
  endtask

  task automatic send_event(logic [15:0] t, logic [15:0] cd, logic [31:0] v);
    send_cmd('{KIND_SUBMIT, t, cd, v});
  endtask

  task automatic send_mix(int unsigned n, int unsigned w_sub, int unsigned w_pop,
                          int unsigned w_open, int unsigned w_close);
    repeat (n) send_kind(pick_kind(w_sub, w_pop, w_open, w_close));
  endtask

  task automatic park_cmd();
    @(negedge clk);
    cmd_valid <= 1'b0;
    burst_left = 0;
  endtask

  // register writes only with the block drained
  task automatic set_buffering(bit on);
    park_cmd();
    while (trk.due_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_data  <= on;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    trk.buffering = on;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    kind_t       k;
    int unsigned at_max;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners, buffering off after reset
    send_event(16'h1234, 16'h5678, 32'h9ABCDEF0);   // no reader: dropped
    send_kind(KIND_POP);                             // pop on empty
    send_kind(KIND_CLOSE);                           // close at zero
    send_kind(KIND_OPEN);
    send_event(16'h0000, 16'h0000, 32'h00000000);
    send_event(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_event(16'hA5A5, 16'h5A5A, 32'h80000001);
    repeat (2) send_kind(KIND_POP);
    send_kind(KIND_SUBMIT);
    send_kind(KIND_SUBMIT);
    send_kind(KIND_CLOSE);                           // last close discards
    send_kind(KIND_POP);
    send_kind(KIND_SUBMIT);
    set_buffering(1'b1);
    send_event(16'h8000, 16'h0001, 32'h7FFFFFFF);   // stored with no reader
    send_kind(KIND_CLOSE);
    send_kind(KIND_OPEN);
    send_kind(KIND_CLOSE);                           // buffering on: kept
    send_kind(KIND_POP);
    send_kind(KIND_POP);
    set_buffering(1'b0);

    send_mix(100, 40, 30, 15, 15);

    // fill to full with no reader, then the double-drop and full-drop cases
    set_buffering(1'b1);
    while (trk.reader_cnt != 0) send_kind(KIND_CLOSE);
    while (trk.stored() < DEPTH_DEF - 1) send_kind(KIND_SUBMIT);
    send_kind(KIND_SUBMIT);
    set_buffering(1'b0);
    repeat (2) send_kind(KIND_SUBMIT);
    send_kind(KIND_OPEN);
    repeat (2) send_kind(KIND_SUBMIT);
    while (trk.stored() != 0) send_kind(pick_kind(20, 80, 0, 0));
    send_kind(KIND_POP);

    // drive the reader count into saturation
    at_max = 0;
    while (at_max < 3) begin
      k = pick_kind(10, 10, 80, 0);
      if (k == KIND_OPEN && trk.reader_cnt == MAX_READERS_DEF) at_max++;
      send_kind(k);
    end

    // release all readers with buffering on, then random walk near zero
    set_buffering(1'b1);
    while (trk.reader_cnt != 0) send_kind(pick_kind(15, 10, 0, 75));
    send_mix(20, 30, 30, 0, 0);
    set_buffering(1'b0);
    send_kind(KIND_SUBMIT);
    send_mix(50, 40, 20, 20, 20);
    set_buffering(1'b1);
    send_mix(60, 40, 30, 15, 15);

    park_cmd();
    while (trk.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (trk.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- event_ring_queue.f -----
src/erq_pkg.sv
src/event_ring_queue.sv
verif/tb.sv
